@@ rtl/yrt_pkg.sv @@
// Shared constants and types for the YUYV to RGB565 red-threshold block.
// No dependencies; imported by the core and its checker.
`default_nettype none

package yrt_pkg;

  typedef logic [7:0] level_t;

  // Register file layout: one 32-bit register at byte address 0.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_RED_THRESHOLD = 3'd0;

  localparam level_t RED_THRESHOLD_RST = 8'd100;

  // Integer BT.601 red coefficients.
  localparam int COEF_Y     = 298;
  localparam int COEF_V     = 409;
  localparam int CHROMA_OFS = 128;
  localparam int ROUND_OFS  = 128;

endpackage

`default_nettype wire

@@ rtl/yuyv_to_rgb565_red_threshold_core.sv @@
// YUYV macropixel to thresholded RGB565 core: BT.601 red, threshold on green/blue.
// Depends on yrt_pkg (types, register map, coefficients).
`default_nettype none

// Channel  | Ports                                     | Handshake
// ---------+-------------------------------------------+------------------------------
// input    | in_luma_first/second, in_chroma_blue/red  | in_valid & !in_stall
// result   | out_first/second_rgb565, out_*_level      | out_valid & !out_stall
// config   | psel penable pwrite paddr pwdata prdata   | psel & penable & pwrite
//
// Flow: an accepted item passes from the input register through the conversion into the
// result register, which drives the result ports; one item enters every cycle while
// in_stall is low.
// Reset: rst_n is synchronous and active low; it empties both stages and loads the
// threshold with 100.
// Stalls: out_stall holds the result register; the input register keeps taking items
// until it too is full, so in_stall rises only when both stages hold an item.

module yuyv_to_rgb565_red_threshold_core (
  input  wire                              clk,
  input  wire                              rst_n,
  // input item
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [7:0]                       in_luma_first,
  input  wire  [7:0]                       in_chroma_blue,
  input  wire  [7:0]                       in_luma_second,
  input  wire  [7:0]                       in_chroma_red,
  // result item
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [15:0]                      out_first_rgb565,
  output logic [15:0]                      out_second_rgb565,
  output logic [7:0]                       out_first_red_level,
  output logic [7:0]                       out_first_green_blue_level,
  output logic [7:0]                       out_second_red_level,
  output logic [7:0]                       out_second_green_blue_level,
  // configuration
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [yrt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [yrt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [yrt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import yrt_pkg::*;

  // Red level of one pixel: clamp((298*Y + 409*(V-128) + 128) >> 8) to 0..255.
  // The sum spans -52224..128061, so 19 signed bits hold it.
  function automatic level_t red_level(input logic [7:0] luma, input logic [7:0] vbyte);
    logic signed [18:0] sum;
    sum = 19'(COEF_Y) * $signed({11'b0, luma})
        + 19'(COEF_V) * ($signed({11'b0, vbyte}) - 19'(CHROMA_OFS))
        + 19'(ROUND_OFS);
    if (sum[18]) begin
      red_level = '0;
    end else if (|sum[17:16]) begin
      red_level = '1;
    end else begin
      red_level = sum[15:8];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration: decoded per 32-bit word, only the low register exists.
  // ---------------------------------------------------------------------------
  level_t red_thr_r;
  logic   cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_RED_THRESHOLD[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_thr_r <= RED_THRESHOLD_RST;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      red_thr_r <= pwdata[7:0];
    end
  end

  assign prdata = cfg_hit ? {{(CFG_DATA_W-8){1'b0}}, red_thr_r} : '0;

  // ---------------------------------------------------------------------------
  // Stage 1: input register. U is not needed, since green and blue are replaced.
  // ---------------------------------------------------------------------------
  logic       s1_valid_r;
  logic [7:0] s1_luma0_r;
  logic [7:0] s1_luma1_r;
  logic [7:0] s1_vbyte_r;
  logic       advance;
  logic       in_take;

  // Stage 1 moves on whenever the result register is empty or being drained.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_luma0_r <= in_luma_first;
      s1_luma1_r <= in_luma_second;
      s1_vbyte_r <= in_chroma_red;
    end
  end

  // ---------------------------------------------------------------------------
  // Conversion: two red levels, threshold, RGB565 pack.
  // ---------------------------------------------------------------------------
  level_t red0, red1, gb0, gb1;

  always_comb begin
    red0 = red_level(s1_luma0_r, s1_vbyte_r);
    red1 = red_level(s1_luma1_r, s1_vbyte_r);
    // below threshold: drop green and blue, else copy red into both
    gb0  = (red0 < red_thr_r) ? '0 : red0;
    gb1  = (red1 < red_thr_r) ? '0 : red1;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: result register, held while it holds an item and out_stall is high.
  // ---------------------------------------------------------------------------
  logic   out_valid_r;
  level_t red0_r, red1_r, gb0_r, gb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      red0_r <= red0;
      red1_r <= red1;
      gb0_r  <= gb0;
      gb1_r  <= gb1;
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_first_red_level         = red0_r;
  assign out_first_green_blue_level  = gb0_r;
  assign out_second_red_level        = red1_r;
  assign out_second_green_blue_level = gb1_r;
  assign out_first_rgb565            = {red0_r[7:3], gb0_r[7:2], gb0_r[7:3]};
  assign out_second_rgb565           = {red1_r[7:3], gb1_r[7:2], gb1_r[7:3]};

endmodule

`default_nettype wire

@@ rtl/yrt_checker.sv @@
// Port-level checker for yuyv_to_rgb565_red_threshold_core, bound to the core below.
// Depends on yrt_pkg (register map constants).
`default_nettype none

module yrt_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_stall,
  input wire                            out_valid,
  input wire                            out_stall,
  input wire [15:0]                     out_first_rgb565,
  input wire [15:0]                     out_second_rgb565,
  input wire [7:0]                      out_first_red_level,
  input wire [7:0]                      out_first_green_blue_level,
  input wire [7:0]                      out_second_red_level,
  input wire [7:0]                      out_second_green_blue_level,
  input wire                            psel,
  input wire                            penable,
  input wire                            pwrite,
  input wire [yrt_pkg::CFG_ADDR_W-1:0]  paddr,
  input wire [yrt_pkg::CFG_DATA_W-1:0]  prdata
);
  import yrt_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input backs up only when the result side holds an item that is stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A stalled result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_first_rgb565)
                                  && $stable(out_second_rgb565)))
    else $error("stalled result changed");

  // Green/blue is zero or red; the red fields of both words, the green of the first and the blue of the second match.
  a_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_first_green_blue_level == 8'd0
        || out_first_green_blue_level == out_first_red_level)
       && (out_second_green_blue_level == 8'd0
        || out_second_green_blue_level == out_second_red_level)
       && out_first_rgb565[15:11] == out_first_red_level[7:3]
       && out_second_rgb565[15:11] == out_second_red_level[7:3]
       && out_first_rgb565[10:5] == out_first_green_blue_level[7:2]
       && out_second_rgb565[4:0] == out_second_green_blue_level[7:3]))
    else $error("result fields inconsistent");

  // Only the threshold bits can read back nonzero.
  a_prdata: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && !pwrite && paddr[CFG_ADDR_W-1:2] == REG_RED_THRESHOLD[CFG_ADDR_W-1:2])
      |-> (prdata[CFG_DATA_W-1:8] == '0))
    else $error("threshold readback has upper bits set");

endmodule

bind yuyv_to_rgb565_red_threshold_core yrt_checker u_yrt_checker (.*);

`default_nettype wire
